// ----- hw/rtl/lcdcrp_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdcrp_pkg
// Shared types, sizes and helpers for the display command RAM port.
// ----------------------------------------------------------------------------
package lcdcrp_pkg;

    // RAM sizes in bytes
    localparam int DISPLAY_BYTES    = 25;
    localparam int PICTOGRAPH_BYTES = 8;
    localparam int CHARGEN_BYTES    = 112;

    // All three RAMs share one store, laid out back to back
    localparam int DISPLAY_BASE = 0;
    localparam int PICTO_BASE   = DISPLAY_BYTES;
    localparam int CHARGEN_BASE = DISPLAY_BYTES + PICTOGRAPH_BYTES;
    localparam int STORE_DEPTH  = DISPLAY_BYTES + PICTOGRAPH_BYTES + CHARGEN_BYTES;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    localparam int ADDR_W = 7;
    localparam int MODE_W = 3;

    // Command byte decode
    localparam logic [7:0] CMD_KIND_MASK = 8'hC0;
    localparam logic [7:0] CMD_DATA_SET  = 8'h40;
    localparam logic [7:0] CMD_ADDR_SET  = 8'h80;
    localparam logic [7:0] MODE_MASK     = 8'h07;
    localparam logic [7:0] INC_OFF_MASK  = 8'h08;
    localparam logic [7:0] ADDR_MASK     = 8'h1F;
    localparam logic [7:0] CHAR_LIMIT    = 8'h10;
    localparam logic [7:0] CHAR_STRIDE   = 8'd7;

    // Opcodes of the input item
    localparam logic OP_FRAME_BYTE = 1'b0;
    localparam logic OP_CLEAR      = 1'b1;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] REG_CODE_DISPLAY   = 2'd0;
    localparam logic [1:0] REG_CODE_PICTOGRAPH = 2'd1;
    localparam logic [1:0] REG_CODE_CHARGEN   = 2'd2;
    localparam logic [MODE_W-1:0] CODE_DISPLAY_RST   = 3'd0;
    localparam logic [MODE_W-1:0] CODE_PICTOGRAPH_RST = 3'd1;
    localparam logic [MODE_W-1:0] CODE_CHARGEN_RST   = 3'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Write area codes as reported on the result
    localparam logic [1:0] WAREA_DISPLAY = 2'd0;
    localparam logic [1:0] WAREA_PICTO   = 2'd1;
    localparam logic [1:0] WAREA_CHARGEN = 2'd2;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_CLEAR,
        KIND_DATA_SET,
        KIND_ADDR_SET,
        KIND_WRITE
    } t_kind;

    typedef enum logic [1:0] {
        AREA_NONE    = 2'd0,
        AREA_DISPLAY = 2'd1,
        AREA_PICTO   = 2'd2,
        AREA_CHARGEN = 2'd3
    } t_area;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] code_display;
        logic [MODE_W-1:0] code_pictograph;
        logic [MODE_W-1:0] code_chargen;
    } t_cfg;

    // Size of the selected RAM, zero when none is selected
    function automatic logic [7:0] area_size(input t_area area);
        case (area)
            AREA_DISPLAY: area_size = 8'(DISPLAY_BYTES);
            AREA_PICTO:   area_size = 8'(PICTOGRAPH_BYTES);
            AREA_CHARGEN: area_size = 8'(CHARGEN_BYTES);
            default:      area_size = 8'd0;
        endcase
    endfunction

    // First entry of the selected RAM in the shared store
    function automatic logic [STORE_AW-1:0] area_base(input t_area area);
        case (area)
            AREA_PICTO:   area_base = STORE_AW'(PICTO_BASE);
            AREA_CHARGEN: area_base = STORE_AW'(CHARGEN_BASE);
            default:      area_base = STORE_AW'(DISPLAY_BASE);
        endcase
    endfunction

    // Reported area code, also the dirty flag bit
    function automatic logic [1:0] area_code(input t_area area);
        case (area)
            AREA_PICTO:   area_code = WAREA_PICTO;
            AREA_CHARGEN: area_code = WAREA_CHARGEN;
            default:      area_code = WAREA_DISPLAY;
        endcase
    endfunction

endpackage

// ----- hw/rtl/lcdcrp_front.sv -----
// ----------------------------------------------------------------------------
// lcdcrp_front
// Takes input items and classifies each byte as command or data.
// ----------------------------------------------------------------------------
module lcdcrp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [7:0]          i_frame_byte,
    input  logic                i_frame_start,
    input  logic                i_q_full,
    output logic                o_push,
    output lcdcrp_pkg::t_item   o_item
);

    logic              r_valid;
    lcdcrp_pkg::t_item r_item;
    lcdcrp_pkg::t_item n_item;
    logic              accept;

    // Holding register stalls only when the queue is full
    assign o_in_stall = r_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_item     = r_item;

    // Classification
    always_comb begin
        n_item.data = i_frame_byte;
        if (i_opcode == lcdcrp_pkg::OP_CLEAR) begin
            n_item.kind = lcdcrp_pkg::KIND_CLEAR;
        end else if (!i_frame_start) begin
            n_item.kind = lcdcrp_pkg::KIND_WRITE;
        end else if ((i_frame_byte & lcdcrp_pkg::CMD_KIND_MASK) == lcdcrp_pkg::CMD_DATA_SET) begin
            n_item.kind = lcdcrp_pkg::KIND_DATA_SET;
        end else if ((i_frame_byte & lcdcrp_pkg::CMD_KIND_MASK) == lcdcrp_pkg::CMD_ADDR_SET) begin
            n_item.kind = lcdcrp_pkg::KIND_ADDR_SET;
        end else begin
            n_item.kind = lcdcrp_pkg::KIND_NOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept | (r_valid & ~o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hw/rtl/lcdcrp_queue.sv -----
// ----------------------------------------------------------------------------
// lcdcrp_queue
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module lcdcrp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdcrp_pkg::t_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output lcdcrp_pkg::t_item o_item
);

    lcdcrp_pkg::t_item                    r_entry [lcdcrp_pkg::QUEUE_DEPTH];
    logic [lcdcrp_pkg::QUEUE_PW-1:0]      r_wr_ptr;
    logic [lcdcrp_pkg::QUEUE_PW-1:0]      r_rd_ptr;
    logic [lcdcrp_pkg::QUEUE_CW-1:0]      r_count;
    logic                                 push_ok;
    logic                                 pop_ok;

    assign o_full  = (r_count == lcdcrp_pkg::QUEUE_CW'(lcdcrp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == lcdcrp_pkg::QUEUE_PW'(lcdcrp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == lcdcrp_pkg::QUEUE_PW'(lcdcrp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/lcdcrp_back.sv -----
// ----------------------------------------------------------------------------
// lcdcrp_back
// Carries out items: address/mode update and store read, then compare,
// write and dirty flag update, then the result register.
// ----------------------------------------------------------------------------
module lcdcrp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcdcrp_pkg::t_cfg                  i_cfg,
    input  logic                              i_q_empty,
    input  lcdcrp_pkg::t_item                 i_q_item,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_write_done,
    output logic [1:0]                        o_write_area,
    output logic [lcdcrp_pkg::ADDR_W-1:0]     o_write_address,
    output logic                              o_write_changed,
    output logic                              o_display_dirty,
    output logic                              o_pictograph_dirty,
    output logic                              o_chargen_dirty,
    output logic [1:0]                        o_selected_area,
    output logic [lcdcrp_pkg::ADDR_W-1:0]     o_current_address,
    output logic                              o_increment_on
);

    localparam int AW       = lcdcrp_pkg::ADDR_W;
    localparam int SW       = lcdcrp_pkg::STORE_AW;
    localparam int MODE_W_L = lcdcrp_pkg::MODE_W;

    // Shared byte store with per-entry valid bits (invalid reads as zero)
    logic [7:0]                       r_store [lcdcrp_pkg::STORE_DEPTH];
    logic [lcdcrp_pkg::STORE_DEPTH-1:0] r_store_valid;

    // Port state
    lcdcrp_pkg::t_area r_area;
    logic [AW-1:0]     r_addr;
    logic              r_inc;
    logic [2:0]        r_dirty;

    // Second stage
    logic              r_b_valid;
    lcdcrp_pkg::t_kind r_b_kind;
    logic              r_b_done;
    logic [1:0]        r_b_warea;
    logic [AW-1:0]     r_b_waddr;
    logic [SW-1:0]     r_b_index;
    logic [7:0]        r_b_data;
    logic [1:0]        r_b_sel_area;
    logic [AW-1:0]     r_b_cur_addr;
    logic              r_b_inc;
    logic [7:0]        r_b_rd_data;
    logic              r_b_rd_valid;
    logic              r_b_fwd;
    logic [7:0]        r_b_fwd_data;

    // Result register
    logic              r_out_valid;
    logic              r_out_done;
    logic [1:0]        r_out_warea;
    logic [AW-1:0]     r_out_waddr;
    logic              r_out_changed;
    logic [2:0]        r_out_dirty;
    logic [1:0]        r_out_sel_area;
    logic [AW-1:0]     r_out_cur_addr;
    logic              r_out_inc;

    // First stage signals
    lcdcrp_pkg::t_area n_area;
    logic [AW-1:0]     n_addr;
    logic              n_inc;
    logic              a_done;
    logic [1:0]        a_warea;
    logic [AW-1:0]     a_waddr;
    logic [SW-1:0]     a_index;
    logic [7:0]        size_cur;
    logic [7:0]        size_new;
    logic [7:0]        addr_inc;
    logic [7:0]        addr_field;
    logic [7:0]        char_start;
    logic [MODE_W_L-1:0] mode;
    logic              adv;

    // Second stage signals
    logic [7:0]        b_old;
    logic              b_write;
    logic              b_changed;
    logic [2:0]        n_dirty;

    assign adv   = ~r_out_valid | ~i_out_stall;
    assign o_pop = adv & ~i_q_empty;

    // ---- First stage: mode and address update ----
    assign size_cur   = lcdcrp_pkg::area_size(r_area);
    assign size_new   = lcdcrp_pkg::area_size(n_area);
    assign addr_inc   = {1'b0, r_addr} + 8'd1;
    assign addr_field = i_q_item.data & lcdcrp_pkg::ADDR_MASK;
    assign char_start = (addr_field & 8'h0F) * lcdcrp_pkg::CHAR_STRIDE;
    assign mode       = MODE_W_L'(i_q_item.data & lcdcrp_pkg::MODE_MASK);
    assign a_index    = lcdcrp_pkg::area_base(r_area) + SW'(r_addr);

    always_comb begin
        n_area  = r_area;
        n_addr  = r_addr;
        n_inc   = r_inc;
        a_done  = 1'b0;
        a_warea = '0;
        a_waddr = '0;
        case (i_q_item.kind)
            lcdcrp_pkg::KIND_DATA_SET: begin
                if (mode == i_cfg.code_display) begin
                    n_area = lcdcrp_pkg::AREA_DISPLAY;
                    n_inc  = ((i_q_item.data & lcdcrp_pkg::INC_OFF_MASK) == 8'd0);
                end else if (mode == i_cfg.code_pictograph) begin
                    n_area = lcdcrp_pkg::AREA_PICTO;
                    n_inc  = ((i_q_item.data & lcdcrp_pkg::INC_OFF_MASK) == 8'd0);
                end else if (mode == i_cfg.code_chargen) begin
                    n_area = lcdcrp_pkg::AREA_CHARGEN;
                    n_inc  = 1'b1;
                    n_addr = '0;
                end else begin
                    n_area = lcdcrp_pkg::AREA_NONE;
                    n_inc  = 1'b1;
                    n_addr = '0;
                end
                // wrap into the newly selected RAM
                if ({1'b0, n_addr} >= size_new) begin
                    n_addr = '0;
                end
            end
            lcdcrp_pkg::KIND_ADDR_SET: begin
                if (r_area == lcdcrp_pkg::AREA_DISPLAY || r_area == lcdcrp_pkg::AREA_PICTO) begin
                    n_addr = (addr_field >= size_cur) ? '0 : AW'(addr_field);
                end else if (r_area == lcdcrp_pkg::AREA_CHARGEN) begin
                    // character number times seven, zero when out of range
                    if (addr_field < lcdcrp_pkg::CHAR_LIMIT &&
                        char_start < 8'(lcdcrp_pkg::CHARGEN_BYTES)) begin
                        n_addr = AW'(char_start);
                    end else begin
                        n_addr = '0;
                    end
                end
            end
            lcdcrp_pkg::KIND_WRITE: begin
                if (r_area != lcdcrp_pkg::AREA_NONE && {1'b0, r_addr} < size_cur) begin
                    a_done  = 1'b1;
                    a_warea = lcdcrp_pkg::area_code(r_area);
                    a_waddr = r_addr;
                    if (r_inc) begin
                        n_addr = (addr_inc >= size_cur) ? '0 : AW'(addr_inc);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---- Second stage: compare, write, dirty flags ----
    assign b_old     = r_b_fwd ? r_b_fwd_data : (r_b_rd_valid ? r_b_rd_data : 8'd0);
    assign b_write   = r_b_valid & r_b_done;
    assign b_changed = b_write & (b_old != r_b_data);

    always_comb begin
        n_dirty = r_dirty;
        if (r_b_valid && r_b_kind == lcdcrp_pkg::KIND_CLEAR) begin
            n_dirty = '0;
        end
        if (b_changed) begin
            n_dirty[r_b_warea] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area        <= lcdcrp_pkg::AREA_NONE;
            r_addr        <= '0;
            r_inc         <= 1'b0;
            r_dirty       <= '0;
            r_b_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_store_valid <= '0;
        end else if (adv) begin
            r_b_valid   <= o_pop;
            r_out_valid <= r_b_valid;
            r_dirty     <= n_dirty;
            if (o_pop) begin
                r_area <= n_area;
                r_addr <= n_addr;
                r_inc  <= n_inc;
            end
            if (b_write) begin
                r_store_valid[r_b_index] <= 1'b1;
            end
        end
    end

    // Store, pipeline payload and result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (b_write) begin
                r_store[r_b_index] <= r_b_data;
            end
            // read for the next item; a write to the same entry in this
            // cycle is forwarded
            r_b_rd_data  <= r_store[a_index];
            r_b_rd_valid <= r_store_valid[a_index];
            r_b_fwd      <= b_write & (r_b_index == a_index);
            r_b_fwd_data <= r_b_data;

            r_b_kind     <= i_q_item.kind;
            r_b_done     <= a_done;
            r_b_warea    <= a_warea;
            r_b_waddr    <= a_waddr;
            r_b_index    <= a_index;
            r_b_data     <= i_q_item.data;
            r_b_sel_area <= n_area;
            r_b_cur_addr <= n_addr;
            r_b_inc      <= n_inc;

            r_out_done     <= r_b_done;
            r_out_warea    <= r_b_warea;
            r_out_waddr    <= r_b_waddr;
            r_out_changed  <= b_changed;
            r_out_dirty    <= n_dirty;
            r_out_sel_area <= r_b_sel_area;
            r_out_cur_addr <= r_b_cur_addr;
            r_out_inc      <= r_b_inc;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_write_done       = r_out_done;
    assign o_write_area       = r_out_warea;
    assign o_write_address    = r_out_waddr;
    assign o_write_changed    = r_out_changed;
    assign o_display_dirty    = r_out_dirty[lcdcrp_pkg::WAREA_DISPLAY];
    assign o_pictograph_dirty = r_out_dirty[lcdcrp_pkg::WAREA_PICTO];
    assign o_chargen_dirty    = r_out_dirty[lcdcrp_pkg::WAREA_CHARGEN];
    assign o_selected_area    = r_out_sel_area;
    assign o_current_address  = r_out_cur_addr;
    assign o_increment_on     = r_out_inc;

endmodule

// ----- hw/rtl/lcd_controller_command_ram_port.sv -----
// ----------------------------------------------------------------------------
// lcd_controller_command_ram_port
// Serial command port of a display controller, one received byte per item.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one received byte with its
// opcode and frame-start flag; output channel (o_out_valid / i_out_stall)
// returns one result item per input item, in order: write report, dirty
// flags and the selected RAM, address and increment mode after the byte.
// Mode codes are set through the APB port (0x0 display, 0x4 pictograph,
// 0x8 character generator); write them only while the block is idle.
// Throughput: one item per cycle while the receiver does not stall. Input items
// pass the classify register, which loads at the accept edge, then a queue entry,
// the store read stage, and the compare/write stage feeding the result register.
// The store is one 145-byte RAM for all three areas with one read and one
// write per cycle; a write and a read of the same entry in back-to-back
// items is forwarded.
// Reset clears the RAM valid bits (all bytes read as zero), the dirty flags,
// the selection and the address, and empties the pipeline; no clearing pass.
// When the receiver stalls the result register holds, the back end stops,
// and input items keep being taken until the queue and front register fill.
// ----------------------------------------------------------------------------
module lcd_controller_command_ram_port (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcdcrp_pkg::CFG_AW-1:0]     paddr,
    input  logic [lcdcrp_pkg::CFG_DW-1:0]     pwdata,
    output logic [lcdcrp_pkg::CFG_DW-1:0]     prdata,
    output logic                              pready,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [7:0]                        i_frame_byte,
    input  logic                              i_frame_start,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_write_done,
    output logic [1:0]                        o_write_area,
    output logic [lcdcrp_pkg::ADDR_W-1:0]     o_write_address,
    output logic                              o_write_changed,
    output logic                              o_display_dirty,
    output logic                              o_pictograph_dirty,
    output logic                              o_chargen_dirty,
    output logic [1:0]                        o_selected_area,
    output logic [lcdcrp_pkg::ADDR_W-1:0]     o_current_address,
    output logic                              o_increment_on
);

    lcdcrp_pkg::t_cfg  r_cfg;
    lcdcrp_pkg::t_item front_item;
    lcdcrp_pkg::t_item q_item;
    logic              front_push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              cfg_write;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_display    <= lcdcrp_pkg::CODE_DISPLAY_RST;
            r_cfg.code_pictograph <= lcdcrp_pkg::CODE_PICTOGRAPH_RST;
            r_cfg.code_chargen    <= lcdcrp_pkg::CODE_CHARGEN_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                lcdcrp_pkg::REG_CODE_DISPLAY:    r_cfg.code_display    <= pwdata[2:0];
                lcdcrp_pkg::REG_CODE_PICTOGRAPH: r_cfg.code_pictograph <= pwdata[2:0];
                lcdcrp_pkg::REG_CODE_CHARGEN:    r_cfg.code_chargen    <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            lcdcrp_pkg::REG_CODE_DISPLAY:
                prdata = lcdcrp_pkg::CFG_DW'(r_cfg.code_display);
            lcdcrp_pkg::REG_CODE_PICTOGRAPH:
                prdata = lcdcrp_pkg::CFG_DW'(r_cfg.code_pictograph);
            lcdcrp_pkg::REG_CODE_CHARGEN:
                prdata = lcdcrp_pkg::CFG_DW'(r_cfg.code_chargen);
            default:
                prdata = '0;
        endcase
    end

    lcdcrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_frame_byte  (i_frame_byte),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (front_push),
        .o_item        (front_item)
    );

    lcdcrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    lcdcrp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .i_q_item           (q_item),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_write_done       (o_write_done),
        .o_write_area       (o_write_area),
        .o_write_address    (o_write_address),
        .o_write_changed    (o_write_changed),
        .o_display_dirty    (o_display_dirty),
        .o_pictograph_dirty (o_pictograph_dirty),
        .o_chargen_dirty    (o_chargen_dirty),
        .o_selected_area    (o_selected_area),
        .o_current_address  (o_current_address),
        .o_increment_on     (o_increment_on)
    );

endmodule

// ----- verif/tb_lcd_controller_command_ram_port.sv -----
// ----------------------------------------------------------------------------
// tb_lcd_controller_command_ram_port
// Self-checking testbench for the display controller command RAM port.
// A queue of received bytes feeds a clocked driver. Each accepted byte is
// run through a local model of the three RAMs, the selection, the address
// and the dirty flags. The monitor compares every result item with the
// oldest prediction. Mode codes are rewritten over the APB port between
// phases. Both channels idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_lcd_controller_command_ram_port;

    timeunit 1ns;
    timeprecision 1ps;

    // One received byte as it goes to the input channel
    typedef struct packed {
        logic       opcode;
        logic [7:0] data;
        logic       start;
    } t_rx_byte;

    // One predicted result item
    typedef struct packed {
        logic                          write_done;
        logic [1:0]                    write_area;
        logic [lcdcrp_pkg::ADDR_W-1:0] write_address;
        logic                          write_changed;
        logic                          display_dirty;
        logic                          pictograph_dirty;
        logic                          chargen_dirty;
        lcdcrp_pkg::t_area             selected_area;
        logic [lcdcrp_pkg::ADDR_W-1:0] current_address;
        logic                          increment_on;
    } t_port_report;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Block inputs, known from time zero
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [lcdcrp_pkg::CFG_AW-1:0] paddr         = '0;
    logic [lcdcrp_pkg::CFG_DW-1:0] pwdata        = '0;
    logic                          i_in_valid    = 1'b0;
    logic                          i_opcode      = lcdcrp_pkg::OP_FRAME_BYTE;
    logic [7:0]                    i_frame_byte  = '0;
    logic                          i_frame_start = 1'b0;
    logic                          i_out_stall   = 1'b0;

    // Block outputs
    logic [lcdcrp_pkg::CFG_DW-1:0] prdata;
    logic                          pready;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_write_done;
    logic [1:0]                    o_write_area;
    logic [lcdcrp_pkg::ADDR_W-1:0] o_write_address;
    logic                          o_write_changed;
    logic                          o_display_dirty;
    logic                          o_pictograph_dirty;
    logic                          o_chargen_dirty;
    logic [1:0]                    o_selected_area;
    logic [lcdcrp_pkg::ADDR_W-1:0] o_current_address;
    logic                          o_increment_on;

    lcd_controller_command_ram_port DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_frame_byte       (i_frame_byte),
        .i_frame_start      (i_frame_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_write_done       (o_write_done),
        .o_write_area       (o_write_area),
        .o_write_address    (o_write_address),
        .o_write_changed    (o_write_changed),
        .o_display_dirty    (o_display_dirty),
        .o_pictograph_dirty (o_pictograph_dirty),
        .o_chargen_dirty    (o_chargen_dirty),
        .o_selected_area    (o_selected_area),
        .o_current_address  (o_current_address),
        .o_increment_on     (o_increment_on)
    );

    // Model state: mode codes, RAM contents, selection, address, flags
    logic [lcdcrp_pkg::MODE_W-1:0] code_disp  = lcdcrp_pkg::CODE_DISPLAY_RST;
    logic [lcdcrp_pkg::MODE_W-1:0] code_picto = lcdcrp_pkg::CODE_PICTOGRAPH_RST;
    logic [lcdcrp_pkg::MODE_W-1:0] code_chgen = lcdcrp_pkg::CODE_CHARGEN_RST;
    logic [7:0] disp_mem  [lcdcrp_pkg::DISPLAY_BYTES]    = '{default: '0};
    logic [7:0] picto_mem [lcdcrp_pkg::PICTOGRAPH_BYTES] = '{default: '0};
    logic [7:0] chgen_mem [lcdcrp_pkg::CHARGEN_BYTES]    = '{default: '0};
    lcdcrp_pkg::t_area             sel_area   = lcdcrp_pkg::AREA_NONE;
    logic [lcdcrp_pkg::ADDR_W-1:0] cur_addr   = '0;
    logic                          inc_on     = 1'b0;
    logic [2:0]                    dirty_bits = '0;

    // Bookkeeping
    t_rx_byte     rx_bytes_todo[$];
    t_port_report reports_due[$];
    t_rx_byte     cur_byte;
    int           items_queued  = 0;
    int           results_seen  = 0;
    int           fail_count    = 0;
    int           send_gap      = 0;
    int           stall_left    = 0;
    bit           idle_on       = 1'b1;

    function automatic int ram_bytes(lcdcrp_pkg::t_area a);
        case (a)
            lcdcrp_pkg::AREA_DISPLAY: return lcdcrp_pkg::DISPLAY_BYTES;
            lcdcrp_pkg::AREA_PICTO:   return lcdcrp_pkg::PICTOGRAPH_BYTES;
            lcdcrp_pkg::AREA_CHARGEN: return lcdcrp_pkg::CHARGEN_BYTES;
            default:                  return 0;
        endcase
    endfunction

    // Address past the end of the selected RAM goes back to 0
    function automatic void wrap_addr();
        if (int'(cur_addr) >= ram_bytes(sel_area)) cur_addr = '0;
    endfunction

    // Apply one byte to the model and return the result it gives
    function automatic t_port_report decode_rx_byte(t_rx_byte rx);
        t_port_report r;
        logic [lcdcrp_pkg::MODE_W-1:0] mode;
        logic [7:0] char_no;
        logic [7:0] old_val;
        r = '0;
        old_val = '0;
        if (rx.opcode == lcdcrp_pkg::OP_CLEAR) begin
            dirty_bits = '0;
        end else if (rx.start) begin
            if ((rx.data & lcdcrp_pkg::CMD_KIND_MASK) == lcdcrp_pkg::CMD_DATA_SET) begin
                // data setting: display beats pictograph beats chargen
                mode = lcdcrp_pkg::MODE_W'(rx.data & lcdcrp_pkg::MODE_MASK);
                if (mode == code_disp) begin
                    sel_area = lcdcrp_pkg::AREA_DISPLAY;
                    inc_on = ((rx.data & lcdcrp_pkg::INC_OFF_MASK) == 8'h00);
                end else if (mode == code_picto) begin
                    sel_area = lcdcrp_pkg::AREA_PICTO;
                    inc_on = ((rx.data & lcdcrp_pkg::INC_OFF_MASK) == 8'h00);
                end else if (mode == code_chgen) begin
                    sel_area = lcdcrp_pkg::AREA_CHARGEN;
                    inc_on = 1'b1;
                    cur_addr = '0;
                end else begin
                    sel_area = lcdcrp_pkg::AREA_NONE;
                    inc_on = 1'b1;
                    cur_addr = '0;
                end
                wrap_addr();
            end else if ((rx.data & lcdcrp_pkg::CMD_KIND_MASK) == lcdcrp_pkg::CMD_ADDR_SET) begin
                // address setting; chargen takes a character number
                char_no = rx.data & lcdcrp_pkg::ADDR_MASK;
                if (sel_area == lcdcrp_pkg::AREA_DISPLAY ||
                    sel_area == lcdcrp_pkg::AREA_PICTO) begin
                    cur_addr = lcdcrp_pkg::ADDR_W'(char_no);
                    wrap_addr();
                end else if (sel_area == lcdcrp_pkg::AREA_CHARGEN) begin
                    if (char_no < lcdcrp_pkg::CHAR_LIMIT &&
                        int'(char_no) * int'(lcdcrp_pkg::CHAR_STRIDE) <
                        lcdcrp_pkg::CHARGEN_BYTES)
                        cur_addr = lcdcrp_pkg::ADDR_W'(int'(char_no) *
                                                       int'(lcdcrp_pkg::CHAR_STRIDE));
                    else
                        cur_addr = '0;
                end
            end
        end else if (sel_area != lcdcrp_pkg::AREA_NONE &&
                     int'(cur_addr) < ram_bytes(sel_area)) begin
            // data byte into the selected RAM
            r.write_done = 1'b1;
            r.write_address = cur_addr;
            case (sel_area)
                lcdcrp_pkg::AREA_DISPLAY: begin
                    old_val = disp_mem[cur_addr];
                    disp_mem[cur_addr] = rx.data;
                    r.write_area = lcdcrp_pkg::WAREA_DISPLAY;
                end
                lcdcrp_pkg::AREA_PICTO: begin
                    old_val = picto_mem[cur_addr];
                    picto_mem[cur_addr] = rx.data;
                    r.write_area = lcdcrp_pkg::WAREA_PICTO;
                end
                default: begin
                    old_val = chgen_mem[cur_addr];
                    chgen_mem[cur_addr] = rx.data;
                    r.write_area = lcdcrp_pkg::WAREA_CHARGEN;
                end
            endcase
            if (old_val != rx.data) begin
                r.write_changed = 1'b1;
                dirty_bits[r.write_area] = 1'b1;
            end
            if (inc_on) begin
                cur_addr = cur_addr + 1'b1;
                wrap_addr();
            end
        end
        r.display_dirty    = dirty_bits[lcdcrp_pkg::WAREA_DISPLAY];
        r.pictograph_dirty = dirty_bits[lcdcrp_pkg::WAREA_PICTO];
        r.chargen_dirty    = dirty_bits[lcdcrp_pkg::WAREA_CHARGEN];
        r.selected_area    = sel_area;
        r.current_address  = cur_addr;
        r.increment_on     = inc_on;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Input driver: holds the item while stalled, gaps in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) reports_due.push_back(decode_rx_byte(cur_byte));
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (rx_bytes_todo.size() > 0) begin
                    cur_byte = rx_bytes_todo.pop_front();
                    i_opcode      <= cur_byte.opcode;
                    i_frame_byte  <= cur_byte.data;
                    i_frame_start <= cur_byte.start;
                    i_in_valid    <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: each accepted result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_port_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                $error("result item with no prediction waiting");
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("write_done", want.write_done, o_write_done);
                check_field("write_area", want.write_area, o_write_area);
                check_field("write_address", want.write_address, o_write_address);
                check_field("write_changed", want.write_changed, o_write_changed);
                check_field("display_dirty", want.display_dirty, o_display_dirty);
                check_field("pictograph_dirty", want.pictograph_dirty, o_pictograph_dirty);
                check_field("chargen_dirty", want.chargen_dirty, o_chargen_dirty);
                check_field("selected_area", want.selected_area, o_selected_area);
                check_field("current_address", want.current_address, o_current_address);
                check_field("increment_on", want.increment_on, o_increment_on);
            end
        end
    end

    task automatic queue_byte(logic op, logic [7:0] b, logic st);
        rx_bytes_todo.push_back('{opcode: op, data: b, start: st});
        items_queued++;
    endtask

    // Wait for every prediction to be matched, then a short pause
    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic apb_write(logic [1:0] reg_idx, logic [lcdcrp_pkg::MODE_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lcdcrp_pkg::CFG_AW'(reg_idx) << 2;
        pwdata  <= {(lcdcrp_pkg::CFG_DW - lcdcrp_pkg::MODE_W)'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode_codes(logic [lcdcrp_pkg::MODE_W-1:0] d,
                                  logic [lcdcrp_pkg::MODE_W-1:0] p,
                                  logic [lcdcrp_pkg::MODE_W-1:0] c);
        apb_write(lcdcrp_pkg::REG_CODE_DISPLAY, d);
        apb_write(lcdcrp_pkg::REG_CODE_PICTOGRAPH, p);
        apb_write(lcdcrp_pkg::REG_CODE_CHARGEN, c);
        code_disp  = d;
        code_picto = p;
        code_chgen = c;
    endtask

    // Mostly well-formed frames with random content, some noise and clears
    task automatic send_random_frames(int n);
        int stop_at;
        int pick;
        logic [lcdcrp_pkg::MODE_W-1:0] mode;
        logic [7:0] cmd;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                queue_byte(lcdcrp_pkg::OP_CLEAR, 8'($urandom()), 1'($urandom()));
            end else if (pick == 1) begin
                queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'($urandom()), 1'($urandom()));
            end else begin
                if (pick < 7) begin
                    case ($urandom_range(0, 3))
                        0:       mode = code_disp;
                        1:       mode = code_picto;
                        2:       mode = code_chgen;
                        default: mode = lcdcrp_pkg::MODE_W'($urandom());
                    endcase
                    cmd = lcdcrp_pkg::CMD_DATA_SET
                          | (8'($urandom()) &
                             ~(lcdcrp_pkg::CMD_KIND_MASK | lcdcrp_pkg::MODE_MASK))
                          | 8'(mode);
                end else begin
                    cmd = lcdcrp_pkg::CMD_ADDR_SET
                          | (8'($urandom()) & ~lcdcrp_pkg::CMD_KIND_MASK);
                end
                queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, cmd, 1'b1);
                // small values half the time so that rewrites often match
                repeat ($urandom_range(0, 10))
                    queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                               $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom()),
                               1'b0);
            end
        end
    endtask

    // Main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clear, stray data, ignored command kinds
        queue_byte(lcdcrp_pkg::OP_CLEAR, 8'hFF, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h5A, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h00, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'hFF, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, lcdcrp_pkg::CMD_ADDR_SET | 8'h05, 1'b1);
        // display, increment on; unchanged then changed writes
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_DATA_SET | 8'(lcdcrp_pkg::CODE_DISPLAY_RST), 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h00, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'hFF, 1'b0);
        // last display byte, then wrap; address past the end
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, lcdcrp_pkg::CMD_ADDR_SET | 8'd24, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'hA5, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_ADDR_SET | lcdcrp_pkg::ADDR_MASK, 1'b1);
        // pictograph with increment off
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_DATA_SET | lcdcrp_pkg::INC_OFF_MASK |
                   8'(lcdcrp_pkg::CODE_PICTOGRAPH_RST), 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h81, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h81, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, lcdcrp_pkg::CMD_ADDR_SET | 8'd7, 1'b1);
        // chargen forces increment on; last character, then one too high
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_DATA_SET | lcdcrp_pkg::INC_OFF_MASK |
                   8'(lcdcrp_pkg::CODE_CHARGEN_RST), 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, lcdcrp_pkg::CMD_ADDR_SET | 8'd15, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h7E, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h01, 1'b0);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_ADDR_SET | lcdcrp_pkg::CHAR_LIMIT, 1'b1);
        // unknown mode deselects; data then ignored
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE,
                   lcdcrp_pkg::CMD_DATA_SET | lcdcrp_pkg::MODE_MASK, 1'b1);
        queue_byte(lcdcrp_pkg::OP_FRAME_BYTE, 8'h12, 1'b0);
        queue_byte(lcdcrp_pkg::OP_CLEAR, 8'h00, 1'b0);
        wait_drained();

        // random phases over a range of mode code settings
        set_mode_codes(3'd7, 3'd0, 3'd3);
        send_random_frames(130);
        wait_drained();
        set_mode_codes(3'd5, 3'd5, 3'd5);
        send_random_frames(130);
        wait_drained();
        set_mode_codes(3'd1, 3'd1, 3'd2);
        send_random_frames(130);
        wait_drained();
        set_mode_codes(3'd4, 3'd6, 3'd6);
        send_random_frames(130);
        wait_drained();
        set_mode_codes(lcdcrp_pkg::MODE_W'($urandom()), lcdcrp_pkg::MODE_W'($urandom()),
                       lcdcrp_pkg::MODE_W'($urandom()));
        send_random_frames(130);
        wait_drained();
        // last phase at full rate
        set_mode_codes(3'd0, 3'd1, 3'd2);
        idle_on = 1'b0;
        send_random_frames(130);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (reports_due.size() != 0) begin
            $error("%0d predicted results never arrived", reports_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
